// ===== rtl/itoa_pkg.sv =====
// shared types, constants and the digit table of the integer to ascii formatter
`default_nettype none
package itoa_pkg;

	// number and digit store geometry
	localparam int unsigned VAL_W = 64;
	localparam int unsigned NDIG  = 20;
	localparam int unsigned DIG_W = NDIG * 4;
	localparam int unsigned ND_W  = 5;
	localparam int unsigned CNT_W = 7;

	// bit positions inside format_flags
	localparam int unsigned FLG_ZERO  = 0;
	localparam int unsigned FLG_PLUS  = 1;
	localparam int unsigned FLG_SPACE = 2;
	localparam int unsigned FLG_LEFT  = 3;
	localparam int unsigned FLG_ALT   = 4;

	// ascii codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;

	localparam logic [7:0] HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	// control into the digit converter
	typedef struct packed {
		logic load;
		logic is_hex;
		logic shift;
	} conv_ctl_t;

	// status out of the digit converter
	typedef struct packed {
		logic            done;
		logic [ND_W-1:0] nd;
		logic [3:0]      digit;
	} conv_stat_t;

	// field layout handed to the character emitter
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] lpad;
		logic             sign_en;
		logic [7:0]       sign_ch;
		logic             pfx;
		logic [CNT_W-1:0] zpad;
		logic [ND_W-1:0]  nd;
		logic [CNT_W-1:0] rpad;
		logic [CNT_W-1:0] total;
	} emit_job_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return HEX_DIGITS[d];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/itoa_conv.sv =====
// digit converter: shift-and-add-3 binary to bcd, hex nibble load, leading zero strip
`default_nettype none
module itoa_conv (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire itoa_pkg::conv_ctl_t          ctl,
	input  wire logic [itoa_pkg::VAL_W-1:0]   value,
	output itoa_pkg::conv_stat_t              stat
);

	localparam int unsigned VW   = itoa_pkg::VAL_W;
	localparam int unsigned DW   = itoa_pkg::DIG_W;
	localparam int unsigned ND   = itoa_pkg::NDIG;
	localparam int unsigned NW   = itoa_pkg::ND_W;
	localparam int unsigned IT_W = $clog2(VW);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_DAB  = 2'd1;
	localparam logic [1:0] C_NORM = 2'd2;
	localparam logic [1:0] C_DONE = 2'd3;

	logic [1:0]      ph_q;
	logic [VW-1:0]   bin_q;
	logic [DW-1:0]   bcd_q;
	logic [IT_W-1:0] it_q;
	logic [NW-1:0]   nd_q;
	logic [DW-1:0]   adj;

	// add 3 to every bcd digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	// converter sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= C_IDLE;
			it_q <= '0;
			nd_q <= '0;
		end else if (ctl.load) begin
			nd_q <= NW'(ND);
			it_q <= '0;
			ph_q <= ctl.is_hex ? C_NORM : C_DAB;
		end else begin
			unique case (ph_q)
				C_IDLE: begin
				end
				C_DAB: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(VW - 1)) ph_q <= C_NORM;
				end
				C_NORM: begin
					if (bcd_q[DW-1 -: 4] == 4'd0 && nd_q > NW'(1)) begin
						nd_q <= nd_q - 1'b1;
					end else begin
						ph_q <= C_DONE;
					end
				end
				C_DONE: begin
				end
				default: ph_q <= C_IDLE;
			endcase
		end
	end

	// digit store and binary shift register
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= value;
			bcd_q <= ctl.is_hex ? {(DW - VW)'(0), value} : '0;
		end else begin
			priority case (1'b1)
				ph_q == C_DAB: begin
					{bcd_q, bin_q} <= {adj[DW-2:0], bin_q, 1'b0};
				end
				ph_q == C_NORM && bcd_q[DW-1 -: 4] == 4'd0 && nd_q > NW'(1): begin
					bcd_q <= {bcd_q[DW-5:0], 4'd0};
				end
				ph_q == C_DONE && ctl.shift: begin
					bcd_q <= {bcd_q[DW-5:0], 4'd0};
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.done  = (ph_q == C_DONE);
	assign stat.nd    = nd_q;
	assign stat.digit = bcd_q[DW-1 -: 4];

endmodule
`default_nettype wire

// ===== rtl/itoa_emit.sv =====
// character emitter: walks the field phases and drives the output register
`default_nettype none
module itoa_emit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire itoa_pkg::emit_job_t  job,
	input  wire logic [3:0]           digit,
	output logic                      busy,
	output logic                      shift,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata,   // [7:0] character
	output logic                      m_tlast
);

	localparam int unsigned CW = itoa_pkg::CNT_W;
	localparam int unsigned NW = itoa_pkg::ND_W;

	localparam logic [2:0] E_IDLE = 3'd0;
	localparam logic [2:0] E_LPAD = 3'd1;
	localparam logic [2:0] E_SIGN = 3'd2;
	localparam logic [2:0] E_PFX0 = 3'd3;
	localparam logic [2:0] E_PFXX = 3'd4;
	localparam logic [2:0] E_ZPAD = 3'd5;
	localparam logic [2:0] E_DIG  = 3'd6;
	localparam logic [2:0] E_RPAD = 3'd7;

	logic [2:0]    ph_q;
	logic [CW-1:0] lpad_q;
	logic [CW-1:0] zpad_q;
	logic [CW-1:0] rpad_q;
	logic [CW-1:0] rem_q;
	logic [NW-1:0] nd_q;
	logic          sign_q;
	logic [7:0]    sign_ch_q;
	logic          pfx_q;
	logic          valid_q;
	logic [7:0]    data_q;
	logic          last_q;

	logic          out_free;
	logic          fire;
	logic          adv;
	logic [7:0]    ch;

	assign out_free = !valid_q || m_tready;

	// pick the character of the current phase and whether to move on
	always_comb begin
		fire = 1'b0;
		adv  = 1'b0;
		ch   = itoa_pkg::CH_SPACE;
		unique case (ph_q)
			E_IDLE: begin
			end
			E_LPAD: begin
				if (lpad_q == '0) adv = 1'b1;
				else fire = out_free;
			end
			E_SIGN: begin
				ch = sign_ch_q;
				if (!sign_q) adv = 1'b1;
				else begin
					fire = out_free;
					adv  = out_free;
				end
			end
			E_PFX0: begin
				ch = itoa_pkg::CH_ZERO;
				if (!pfx_q) adv = 1'b1;
				else begin
					fire = out_free;
					adv  = out_free;
				end
			end
			E_PFXX: begin
				ch = itoa_pkg::CH_X;
				if (!pfx_q) adv = 1'b1;
				else begin
					fire = out_free;
					adv  = out_free;
				end
			end
			E_ZPAD: begin
				ch = itoa_pkg::CH_ZERO;
				if (zpad_q == '0) adv = 1'b1;
				else fire = out_free;
			end
			E_DIG: begin
				ch = itoa_pkg::digit_char(digit);
				if (nd_q == '0) adv = 1'b1;
				else fire = out_free;
			end
			E_RPAD: begin
				if (rpad_q == '0) adv = 1'b1;
				else fire = out_free;
			end
			default: begin
			end
		endcase
	end

	assign shift = fire && (ph_q == E_DIG);
	assign busy  = (ph_q != E_IDLE);

	// phase sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= E_IDLE;
			lpad_q    <= '0;
			zpad_q    <= '0;
			rpad_q    <= '0;
			rem_q     <= '0;
			nd_q      <= '0;
			sign_q    <= 1'b0;
			sign_ch_q <= itoa_pkg::CH_SPACE;
			pfx_q     <= 1'b0;
		end else if (job.start) begin
			ph_q      <= E_LPAD;
			lpad_q    <= job.lpad;
			zpad_q    <= job.zpad;
			rpad_q    <= job.rpad;
			rem_q     <= job.total;
			nd_q      <= job.nd;
			sign_q    <= job.sign_en;
			sign_ch_q <= job.sign_ch;
			pfx_q     <= job.pfx;
		end else begin
			if (fire) begin
				rem_q <= rem_q - 1'b1;
				unique case (ph_q)
					E_LPAD:  lpad_q <= lpad_q - 1'b1;
					E_ZPAD:  zpad_q <= zpad_q - 1'b1;
					E_DIG:   nd_q   <= nd_q - 1'b1;
					E_RPAD:  rpad_q <= rpad_q - 1'b1;
					default: begin
					end
				endcase
			end
			if (adv) ph_q <= (ph_q == E_RPAD) ? E_IDLE : ph_q + 3'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_q <= ch;
			last_q <= (rem_q == CW'(1));
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

	// no item gets more characters than its field length
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> rem_q != '0)
		else $error("character emitted beyond the field length");

	// the field is fully counted out when the last phase finishes
	a_all_sent: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == E_RPAD && rpad_q == '0) |-> rem_q == '0)
		else $error("field finished with characters still owed");

	// the last mark does not fall in the left pad or sign phase
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rem_q == CW'(1)) |=> (ph_q != E_LPAD && ph_q != E_SIGN))
		else $error("last character emitted before the body");

endmodule
`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
// top level of the printf-style integer to ascii formatter
`default_nettype none
// Formats one 64-bit number per input item as %d (signed) or %X (unsigned,
// upper case) text and streams it out one character per output item, with
// tlast on the final character. One item is worked at a time; s_tready is low
// from acceptance until the last character has been handed to the output
// register. Decimal conversion runs the shift-and-add-3 unit over all 64 bits,
// hex loads its nibbles at acceptance; then leading zero digits are stripped
// (at most 19), and the layout is handed to the emitter. Emission gives one
// character per cycle while m_tready is high, with a step without output at
// the end of each of the four counted phases (left pad, zero pad, digits,
// right pad) and for each absent sign or prefix character. After the emitter
// is done the item sequencer returns to idle and s_tready rises. The field
// length is max(width, text length), with the width saturated at MAX_WIDTH;
// output stalls lengthen the work on an item.
module integer_to_ascii_formatter #(
	parameter int unsigned MAX_WIDTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // [63:0] value, [70:64] field_width, [75:71] format_flags
	input  wire logic        s_tuser,   // [0] is_hex
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] character
	output logic             m_tlast
);

	localparam int unsigned VW = itoa_pkg::VAL_W;
	localparam int unsigned CW = itoa_pkg::CNT_W;
	localparam int unsigned NW = itoa_pkg::ND_W;
	localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]    st_q;
	logic          hex_q;
	logic [4:0]    flg_q;
	logic [CW-1:0] wid_q;
	logic          sign_q;
	logic [7:0]    sign_ch_q;

	logic          accept;
	logic [VW-1:0] in_value;
	logic [CW-1:0] in_width;
	logic [4:0]    in_flags;
	logic          in_neg;
	logic [VW-1:0] in_mag;

	itoa_pkg::conv_ctl_t  conv_ctl;
	itoa_pkg::conv_stat_t conv_stat;
	itoa_pkg::emit_job_t  job;
	logic                 emit_busy;
	logic                 emit_shift;

	logic          left;
	logic          zero;
	logic          pfx;
	logic [CW-1:0] len;
	logic [CW-1:0] pad;

	// input unpacking and magnitude
	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_value = s_tdata[63:0];
	assign in_width = s_tdata[70:64];
	assign in_flags = s_tdata[75:71];
	assign in_neg   = in_value[VW-1] && !s_tuser;
	assign in_mag   = in_neg ? (VW'(0) - in_value) : in_value;

	// item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: if (accept) st_q <= ST_CONV;
				ST_CONV: if (conv_stat.done) st_q <= ST_EMIT;
				ST_EMIT: if (!emit_busy) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// format capture, width saturated and sign chosen at acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			hex_q  <= s_tuser;
			flg_q  <= in_flags;
			wid_q  <= (in_width > MAXW) ? MAXW : in_width;
			sign_q <= !s_tuser && (in_neg || in_flags[itoa_pkg::FLG_PLUS]
				|| in_flags[itoa_pkg::FLG_SPACE]);
			priority if (in_neg) sign_ch_q <= itoa_pkg::CH_MINUS;
			else if (in_flags[itoa_pkg::FLG_PLUS]) sign_ch_q <= itoa_pkg::CH_PLUS;
			else sign_ch_q <= itoa_pkg::CH_SPACE;
		end
	end

	assign conv_ctl.load   = accept;
	assign conv_ctl.is_hex = s_tuser;
	assign conv_ctl.shift  = emit_shift;

	itoa_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (conv_ctl),
		.value  (in_mag),
		.stat   (conv_stat)
	);

	// field layout from digit count, sign, prefix and width
	always_comb begin
		left = flg_q[itoa_pkg::FLG_LEFT];
		zero = flg_q[itoa_pkg::FLG_ZERO] && !left;
		pfx  = hex_q && flg_q[itoa_pkg::FLG_ALT];
		len  = CW'(conv_stat.nd) + (pfx ? CW'(2) : CW'(0)) + (sign_q ? CW'(1) : CW'(0));
		pad  = (wid_q > len) ? (wid_q - len) : '0;

		job.start   = (st_q == ST_CONV) && conv_stat.done;
		job.lpad    = (!left && !zero) ? pad : '0;
		job.sign_en = sign_q;
		job.sign_ch = sign_ch_q;
		job.pfx     = pfx;
		job.zpad    = zero ? pad : '0;
		job.nd      = NW'(conv_stat.nd);
		job.rpad    = left ? pad : '0;
		job.total   = len + pad;
	end

	itoa_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.digit    (conv_stat.digit),
		.busy     (emit_busy),
		.shift    (emit_shift),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// a new item is never taken while characters are still being produced
	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !emit_busy)
		else $error("input ready while the emitter is busy");

	// the emitter starts only once per item, from the conversion state
	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		job.start |=> (st_q == ST_EMIT && emit_busy))
		else $error("emitter start not followed by emission");

endmodule
`default_nettype wire

// ===== dv/integer_to_ascii_formatter_tb.sv =====
// self-checking testbench for the printf-style integer to ascii formatter
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;

	localparam int MAX_WIDTH   = 64;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 300;
	localparam int PRINT_LIMIT = 60;

	// one expected output character
	typedef struct {
		logic [7:0] ch;
		logic       last;
	} field_char_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;   // [63:0] value, [70:64] field_width, [75:71] format_flags
	logic        s_tuser  = 1'b0; // [0] is_hex
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [7:0] character
	logic        m_tlast;

	field_char_t expected_chars[$];
	int          error_count   = 0;
	int          numbers_sent  = 0;
	int          chars_checked = 0;
	int          idle_cycles   = 0;
	bit          no_stalls     = 1'b0;

	integer_to_ascii_formatter #(
		.MAX_WIDTH(MAX_WIDTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mismatch reporting, printing capped but counting all
	task automatic report_error(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("%0t ERROR: %s", $time, msg);
		error_count++;
	endtask

	// random gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_stalls || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] digit_ascii(input logic [3:0] d);
		if (d < 4'd10)
			return itoa_pkg::CH_ZERO + {4'h0, d};
		return 8'h41 + {4'h0, d} - 8'd10;
	endfunction

	// expected text of one number, appended character by character
	function automatic void predict_field(input logic [63:0] value, input bit is_hex,
			input logic [6:0] width, input logic [4:0] flags);
		logic [63:0] mag;
		logic [7:0]  digs[$];
		logic [7:0]  text[$];
		logic [7:0]  sign_ch;
		int          w, len, pad, n;
		bit          left, zero, alt;
		field_char_t fc;
		w       = (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
		left    = flags[itoa_pkg::FLG_LEFT];
		zero    = flags[itoa_pkg::FLG_ZERO] && !left;
		alt     = is_hex && flags[itoa_pkg::FLG_ALT];
		sign_ch = 8'h00;
		mag     = value;
		if (is_hex) begin
			do begin
				digs.push_front(digit_ascii(mag[3:0]));
				mag = mag >> 4;
			end while (mag != 64'd0);
		end else begin
			// sign choice: minus, then plus, then space
			if (value[63]) begin
				sign_ch = itoa_pkg::CH_MINUS;
				mag     = 64'd0 - value;
			end else if (flags[itoa_pkg::FLG_PLUS]) begin
				sign_ch = itoa_pkg::CH_PLUS;
			end else if (flags[itoa_pkg::FLG_SPACE]) begin
				sign_ch = itoa_pkg::CH_SPACE;
			end
			do begin
				digs.push_front(digit_ascii(4'(mag % 64'd10)));
				mag = mag / 64'd10;
			end while (mag != 64'd0);
		end
		len = digs.size() + (alt ? 2 : 0) + ((sign_ch != 8'h00) ? 1 : 0);
		pad = (w > len) ? w - len : 0;
		// field assembly
		if (!left && !zero)
			repeat (pad) text.push_back(itoa_pkg::CH_SPACE);
		if (sign_ch != 8'h00)
			text.push_back(sign_ch);
		if (alt) begin
			text.push_back(itoa_pkg::CH_ZERO);
			text.push_back(itoa_pkg::CH_X);
		end
		if (zero)
			repeat (pad) text.push_back(itoa_pkg::CH_ZERO);
		foreach (digs[i])
			text.push_back(digs[i]);
		if (left)
			repeat (pad) text.push_back(itoa_pkg::CH_SPACE);
		n = (text.size() > MAX_WIDTH) ? MAX_WIDTH : text.size();
		for (int i = 0; i < n; i++) begin
			fc.ch   = text[i];
			fc.last = (i == n - 1);
			expected_chars.push_back(fc);
		end
	endfunction

	// send one number; caller is aligned to a rising edge
	task automatic send_item(input logic [63:0] value, input bit is_hex,
			input logic [6:0] width, input logic [4:0] flags);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'h0, flags, width, value};
		s_tuser  <= is_hex;
		do @(posedge clk); while (!s_tready);
		predict_field(value, is_hex, width, flags);
		numbers_sent++;
	endtask

	// hold the source until every expected character has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] random_value();
		case ($urandom_range(0, 5))
			0: return 64'($urandom_range(0, 999));
			1: return -64'($urandom_range(0, 999));
			2: return {32'h0, $urandom};
			3: return 64'h1 << $urandom_range(0, 63);
			4: return {1'b1, 63'($urandom_range(0, 15))} ^ {64{$urandom_range(0, 1) == 1}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [6:0] random_width();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 7'($urandom_range(0, 24));
		if (r < 93)
			return 7'($urandom_range(25, 64));
		return 7'($urandom_range(65, 127));
	endfunction

	// zero, the largest and smallest numbers in both bases
	task automatic test_extremes();
		send_item(64'd0, 1'b0, 7'd0, 5'b00000);
		send_item(64'd0, 1'b1, 7'd0, 5'b00000);
		send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 7'd0, 5'b00000);
		send_item(64'h8000_0000_0000_0000, 1'b0, 7'd0, 5'b00000);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 7'd0, 5'b00000);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 7'd0, 5'b00000);
		send_item(64'h8000_0000_0000_0000, 1'b1, 7'd0, 5'b00000);
	endtask

	// plus and space sign flags, plus over space, ignored in hex
	task automatic test_sign_flags();
		send_item(64'd42, 1'b0, 7'd0, 5'b00010);
		send_item(64'd42, 1'b0, 7'd0, 5'b00100);
		send_item(64'd42, 1'b0, 7'd0, 5'b00110);
		send_item(-64'd42, 1'b0, 7'd0, 5'b00110);
		send_item(64'd42, 1'b1, 7'd6, 5'b00110);
	endtask

	// space fill, zero fill, left justify, left over zero, narrow width
	task automatic test_field_fill();
		send_item(64'd123, 1'b0, 7'd8, 5'b00000);
		send_item(-64'd123, 1'b0, 7'd8, 5'b00001);
		send_item(-64'd123, 1'b0, 7'd8, 5'b01000);
		send_item(64'd123, 1'b0, 7'd8, 5'b01011);
		send_item(64'd123456, 1'b0, 7'd3, 5'b00000);
	endtask

	// 0x prefix in hex, also for zero, and ignored in decimal
	task automatic test_hex_prefix();
		send_item(64'd0, 1'b1, 7'd0, 5'b10000);
		send_item(64'hABCDEF, 1'b1, 7'd12, 5'b10001);
		send_item(64'd77, 1'b0, 7'd5, 5'b10000);
		send_item(64'h5A, 1'b1, 7'd10, 5'b11000);
	endtask

	// widths at and above the limit
	task automatic test_width_limit();
		send_item(64'h8000_0000_0000_0000, 1'b0, 7'd64, 5'b00001);
		send_item(64'd9, 1'b0, 7'd127, 5'b00000);
		send_item(64'hFEED, 1'b1, 7'd65, 5'b01000);
		send_item(64'hC0FFEE, 1'b1, 7'd100, 5'b10001);
	endtask

	// random numbers and formats with random idling on both sides
	task automatic test_random_mixed(input int count);
		for (int i = 0; i < count; i++)
			send_item(random_value(), $urandom_range(0, 1), random_width(),
				5'($urandom_range(0, 31)));
	endtask

	// items back to back with the sink always ready
	task automatic test_back_to_back(input int count);
		no_stalls = 1'b1;
		for (int i = 0; i < count; i++)
			send_item(random_value(), $urandom_range(0, 1), 7'($urandom_range(0, 30)),
				5'($urandom_range(0, 31)));
		wait_drained();
		no_stalls = 1'b0;
	endtask

	// sink: alternating ready and stall stretches
	initial begin
		int gap;
		repeat (6) @(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// output checker against the oldest expected character
	always @(posedge clk) begin
		field_char_t fc;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_chars.size() == 0) begin
				report_error($sformatf("unexpected character 0x%02h last %0b", m_tdata, m_tlast));
			end else begin
				fc = expected_chars.pop_front();
				if (m_tdata !== fc.ch)
					report_error($sformatf("character 0x%02h, expected 0x%02h", m_tdata, fc.ch));
				if (m_tlast !== fc.last)
					report_error($sformatf("last %0b, expected %0b on 0x%02h",
						m_tlast, fc.last, fc.ch));
				chars_checked++;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t timeout with %0d characters outstanding", $time,
				expected_chars.size());
			$display("integer_to_ascii_formatter_tb: done, errors");
			$finish;
		end
	end

	// test sequence
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_sign_flags();
		test_field_fill();
		test_hex_prefix();
		test_width_limit();
		test_random_mixed(100);
		wait_drained();
		test_back_to_back(45);
		test_random_mixed(100);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_chars.size() != 0)
			report_error($sformatf("%0d characters never arrived", expected_chars.size()));
		$display("covered %0d numbers in decimal and hex, all flag sets, widths 0 to 127",
			numbers_sent);
		$display("checked %0d characters, %0d mismatches", chars_checked, error_count);
		if (error_count == 0)
			$display("integer_to_ascii_formatter_tb: done, clean");
		else
			$display("integer_to_ascii_formatter_tb: done, errors");
		$finish;
	end

endmodule
